[rtl/circle_duplicate_suppression_unit_defines.svh]
// assertion macros shared by the checker of the circle duplicate suppression unit
// depends on signals clk and rst_n in the scope where the macros are used
`ifndef CIRCLE_DUPLICATE_SUPPRESSION_UNIT_DEFINES_SVH
`define CIRCLE_DUPLICATE_SUPPRESSION_UNIT_DEFINES_SVH

// clocked property, quiet during reset
`define CDS_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("cds check failed");

// plain implication in the same cycle
`define CDS_ASSERT_IMPLY(name, a, b) `CDS_ASSERT(name, (a) |-> (b))

`endif

[rtl/cds_pkg.sv]
// types and constants of the circle duplicate suppression unit
// no dependencies; used by the front, core and top modules of the block
package cds_pkg;

    localparam int MAX_CIRCLES = 64;
    localparam int IDX_W = $clog2(MAX_CIRCLES);
    localparam int CNT_W = IDX_W + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [15:0] SPREAD_OFFSET = 16'd77;
    localparam logic [15:0] THRESH_RESET = 16'd52429;

    typedef struct packed {
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic [15:0] radius;
        logic [15:0] point_count;
        logic [15:0] fit_spread;
    } circle_t;

    typedef struct packed {
        circle_t circle;
        logic    last;
    } item_t;

    // queue head offered to the back part
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

endpackage

[rtl/cds_front.sv]
// front part: takes circle beats and holds them in a short queue
// depends on cds_pkg
module cds_front
    import cds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  item_t       in_item,
    output logic        busy,
    output queue_head_t head,
    input  logic        pop
);

    item_t               fifo_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     fill_reg;
    logic                push;
    logic                do_pop;

    assign busy   = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign push   = start && !busy;
    assign do_pop = pop && (fill_reg != '0);

    assign head.valid = (fill_reg != '0);
    assign head.item  = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !do_pop)
                fill_reg <= fill_reg + 1'b1;
            else if (do_pop && !push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= in_item;
    end

endmodule

[rtl/cds_core.sv]
// back part: stores circles, runs pairwise suppression, emits survivors
// depends on cds_pkg
module cds_core
    import cds_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [15:0]        cfg_data,
    input  queue_head_t        head,
    output logic               pop,
    output logic               result_valid,
    output circle_t            result,
    output logic               none_left,
    output logic               overflow,
    output logic               final_res
);

    typedef enum logic [3:0] {
        ST_LOAD, ST_ROW, ST_COL, ST_READ, ST_PREP, ST_MULT, ST_WIDE,
        ST_DECIDE, ST_EM_READ, ST_EM_OUT, ST_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       n_reg, n_next;
    logic [CNT_W-1:0]       i_reg, i_next;
    logic [CNT_W-1:0]       j_reg, j_next;
    logic [CNT_W-1:0]       k_reg, k_next;
    logic                   ovf_reg, ovf_next;
    logic [MAX_CIRCLES-1:0] alive_reg, alive_next;
    logic [15:0]            thr_reg;
    logic                   res_valid_reg, res_valid_next;
    circle_t                res_reg, res_next;
    logic                   none_reg, none_next;
    logic                   res_ovf_reg, res_ovf_next;
    logic                   final_reg, final_next;
    logic                   mem_we;

    circle_t                mem_reg [MAX_CIRCLES];
    circle_t                rd_a_reg, rd_b_reg;
    logic [IDX_W-1:0]       addr_a;

    // stage a
    logic [16:0]            s_reg;
    logic [15:0]            rmin_reg, rmax_reg;
    logic signed [16:0]     dx_reg, dy_reg;
    logic [15:0]            cnt_a_reg, cnt_b_reg, spr_a_reg, spr_b_reg;
    // stage b
    logic [33:0]            ss_reg;
    logic [32:0]            dd_reg;
    logic [31:0]            tr_reg;
    logic [32:0]            sc_j_reg, sc_i_reg;
    logic [15:0]            rmin_b_reg;
    // stage c
    logic signed [36:0]     p_c;
    logic [49:0]            lhs_reg, rh_lo_reg, rh_hi_reg;
    logic                   zero_reg, neg_reg, higher_reg;
    // decision
    logic [65:0]            rhs_d, lhs_d;
    logic                   dup;

    assign result_valid = res_valid_reg;
    assign result       = res_reg;
    assign none_left    = none_reg;
    assign overflow     = res_ovf_reg;
    assign final_res    = final_reg;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THRESH_RESET;
        else if (cfg_valid)
            thr_reg <= cfg_data;
    end

    // circle store, two registered read ports
    assign addr_a = (state_reg == ST_EM_READ) ? k_reg[IDX_W-1:0] : i_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem_reg[n_reg[IDX_W-1:0]] <= head.item.circle;
        rd_a_reg <= mem_reg[addr_a];
        rd_b_reg <= mem_reg[j_reg[IDX_W-1:0]];
    end

    // similarity and score datapath, one pair in flight
    assign p_c = $signed({3'b000, ss_reg}) - $signed({2'b00, dd_reg, 2'b00});

    always_ff @(posedge clk)
    begin
        s_reg     <= {1'b0, rd_a_reg.radius} + {1'b0, rd_b_reg.radius};
        rmin_reg  <= (rd_a_reg.radius < rd_b_reg.radius) ? rd_a_reg.radius : rd_b_reg.radius;
        rmax_reg  <= (rd_a_reg.radius < rd_b_reg.radius) ? rd_b_reg.radius : rd_a_reg.radius;
        dx_reg    <= 17'(rd_a_reg.center_x) - 17'(rd_b_reg.center_x);
        dy_reg    <= 17'(rd_a_reg.center_y) - 17'(rd_b_reg.center_y);
        cnt_a_reg <= rd_a_reg.point_count;
        cnt_b_reg <= rd_b_reg.point_count;
        spr_a_reg <= rd_a_reg.fit_spread;
        spr_b_reg <= rd_b_reg.fit_spread;

        ss_reg     <= 34'(s_reg) * 34'(s_reg);
        dd_reg     <= 33'(34'(dx_reg * dx_reg)) + 33'(34'(dy_reg * dy_reg));
        tr_reg     <= 32'(thr_reg) * 32'(rmax_reg);
        sc_j_reg   <= 33'(cnt_b_reg) * ({17'b0, spr_a_reg} + 33'(SPREAD_OFFSET));
        sc_i_reg   <= 33'(cnt_a_reg) * ({17'b0, spr_b_reg} + 33'(SPREAD_OFFSET));
        rmin_b_reg <= rmin_reg;

        lhs_reg    <= 50'(p_c[33:0]) * 50'(rmin_b_reg);
        rh_lo_reg  <= 50'(ss_reg) * 50'(tr_reg[15:0]);
        rh_hi_reg  <= 50'(ss_reg) * 50'(tr_reg[31:16]);
        zero_reg   <= (rmin_b_reg == '0) || (p_c == '0);
        neg_reg    <= p_c[36];
        higher_reg <= sc_j_reg > sc_i_reg;
    end

    assign rhs_d = {16'b0, rh_lo_reg} + {rh_hi_reg, 16'b0};
    assign lhs_d = {lhs_reg, 16'b0};
    assign dup   = zero_reg ? (thr_reg == '0) : (!neg_reg && (lhs_d >= rhs_d));

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        ovf_next       = ovf_reg;
        alive_next     = alive_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        none_next      = none_reg;
        res_ovf_next   = res_ovf_reg;
        final_next     = final_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (n_reg < CNT_W'(MAX_CIRCLES))
                    begin
                        mem_we = 1'b1;
                        alive_next[n_reg[IDX_W-1:0]] = (head.item.circle.point_count != '0);
                        n_next = n_reg + 1'b1;
                    end
                    else
                        ovf_next = 1'b1;
                    if (head.item.last)
                    begin
                        i_next     = '0;
                        state_next = ST_ROW;
                    end
                end
            end
            ST_ROW:
            begin
                if (i_reg >= n_reg)
                begin
                    k_next = '0;
                    if (alive_reg == '0)
                    begin
                        res_valid_next = 1'b1;
                        res_next       = '0;
                        none_next      = 1'b1;
                        res_ovf_next   = ovf_reg;
                        final_next     = 1'b1;
                        state_next     = ST_DONE;
                    end
                    else
                        state_next = ST_EM_READ;
                end
                else if (!alive_reg[i_reg[IDX_W-1:0]])
                    i_next = i_reg + 1'b1;
                else
                begin
                    j_next     = i_reg + 1'b1;
                    state_next = ST_COL;
                end
            end
            ST_COL:
            begin
                if (j_reg >= n_reg)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_ROW;
                end
                else if (!alive_reg[j_reg[IDX_W-1:0]])
                    j_next = j_reg + 1'b1;
                else
                    state_next = ST_READ;
            end
            ST_READ:   state_next = ST_PREP;
            ST_PREP:   state_next = ST_MULT;
            ST_MULT:   state_next = ST_WIDE;
            ST_WIDE:   state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if (dup && higher_reg)
                begin
                    alive_next[i_reg[IDX_W-1:0]] = 1'b0;
                    i_next     = i_reg + 1'b1;
                    state_next = ST_ROW;
                end
                else
                begin
                    if (dup)
                        alive_next[j_reg[IDX_W-1:0]] = 1'b0;
                    j_next     = j_reg + 1'b1;
                    state_next = ST_COL;
                end
            end
            ST_EM_READ: state_next = ST_EM_OUT;
            ST_EM_OUT:
            begin
                k_next     = k_reg + 1'b1;
                state_next = ST_EM_READ;
                if (alive_reg[k_reg[IDX_W-1:0]])
                begin
                    res_valid_next = 1'b1;
                    res_next       = rd_a_reg;
                    none_next      = 1'b0;
                    res_ovf_next   = ovf_reg;
                    final_next     = ((alive_reg >> k_reg[IDX_W-1:0]) >> 1) == '0;
                    if (final_next)
                        state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                n_next     = '0;
                ovf_next   = 1'b0;
                alive_next = '0;
                state_next = ST_LOAD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            ovf_reg       <= 1'b0;
            alive_reg     <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
            none_reg      <= 1'b0;
            res_ovf_reg   <= 1'b0;
            final_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            ovf_reg       <= ovf_next;
            alive_reg     <= alive_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
            none_reg      <= none_next;
            res_ovf_reg   <= res_ovf_next;
            final_reg     <= final_next;
        end
    end

endmodule

[rtl/circle_duplicate_suppression_unit.sv]
// flow: a beat waits in the queue and moves to the circle store while the core loads;
// after the last beat up to 64*63/2 live pairs are compared one at a time, each through
// the read, prep, mult, wide and decide states; then each live stored circle is sent out
// throughput: one circle beat per cycle while the 4-beat queue has room; results cannot stall
// reset: rst_n clears the queue, the store count, the flags and the sequencer;
// the threshold returns to 52429, the circle store itself is not cleared
module circle_duplicate_suppression_unit
    import cds_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // circle beats
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] center_x,
    input  logic signed [15:0] center_y,
    input  logic [15:0]        radius,
    input  logic [15:0]        point_count,
    input  logic [15:0]        fit_spread,
    input  logic               last,
    // threshold write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data,
    // result beats, one cycle each
    output logic               result_valid,
    output logic signed [15:0] out_center_x,
    output logic signed [15:0] out_center_y,
    output logic [15:0]        out_radius,
    output logic [15:0]        out_point_count,
    output logic [15:0]        out_spread,
    output logic               none_left,
    output logic               overflow,
    output logic               final_res
);

    item_t       in_item;
    queue_head_t head;
    logic        pop;
    circle_t     result;

    // pack the input beat for the queue
    assign in_item.circle.center_x    = center_x;
    assign in_item.circle.center_y    = center_y;
    assign in_item.circle.radius      = radius;
    assign in_item.circle.point_count = point_count;
    assign in_item.circle.fit_spread  = fit_spread;
    assign in_item.last               = last;

    // the user must write only while idle; the block does not enforce this, so the channel is always open
    assign cfg_ready = 1'b1;

    cds_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .in_item (in_item),
        .busy    (busy),
        .head    (head),
        .pop     (pop)
    );

    cds_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result),
        .none_left    (none_left),
        .overflow     (overflow),
        .final_res    (final_res)
    );

    // unpack the result beat
    assign out_center_x    = result.center_x;
    assign out_center_y    = result.center_y;
    assign out_radius      = result.radius;
    assign out_point_count = result.point_count;
    assign out_spread      = result.fit_spread;

endmodule

[rtl/cds_checker.sv]
// port-level checks on the circle duplicate suppression unit, bound to the top level
// depends on circle_duplicate_suppression_unit_defines.svh
`include "circle_duplicate_suppression_unit_defines.svh"
module cds_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic [15:0] out_radius,
    input logic [15:0] out_point_count,
    input logic        none_left,
    input logic        final_res
);

    `CDS_ASSERT_IMPLY(empty_is_final, result_valid && none_left, final_res)
    `CDS_ASSERT_IMPLY(empty_is_zero, result_valid && none_left, out_radius == '0 && out_point_count == '0)
    `CDS_ASSERT_IMPLY(survivor_has_count, result_valid && !none_left, out_point_count != '0)
    `CDS_ASSERT(gap_after_final, (result_valid && final_res) |=> !result_valid)

endmodule

bind circle_duplicate_suppression_unit cds_checker u_cds_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .result_valid    (result_valid),
    .out_radius      (out_radius),
    .out_point_count (out_point_count),
    .none_left       (none_left),
    .final_res       (final_res)
);
